@@ src/biu_pkg.sv @@
package biu_pkg;

  // Image geometry and number formats
  localparam int SRC_SIZE    = 28;
  localparam int DST_SIZE    = 224;
  localparam int WEIGHT_BITS = 8;

  localparam int PIX_W = 16;   // Q8.8 pixel
  localparam int SRC_W = 5;    // source row / column field
  localparam int DC_W  = 8;    // output row / column field

  localparam int DM1   = DST_SIZE - 1;
  localparam int IDX_W = $clog2(SRC_SIZE);

  // Four banks by row and column parity, each HALF x HALF
  localparam int NUM_BANKS  = 4;
  localparam int BANK_W     = 2;
  localparam int HALF       = (SRC_SIZE + 1) / 2;
  localparam int HIDX_W     = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int BANK_DEPTH = HALF * HALF;
  localparam int BADDR_W    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Constant divide by DM1: reciprocal multiply, then one correction step
  localparam int NUM_W  = $clog2(DM1 * (SRC_SIZE - 1) + 1);
  localparam int QSH    = NUM_W;
  localparam int RCP    = (2 ** QSH) / DM1;
  localparam int RCP_W  = QSH + 1;
  localparam int REM_W  = $clog2(DM1 + 1);
  localparam int WN_W   = REM_W + WEIGHT_BITS;
  localparam int WSH    = WN_W;
  localparam int RCPW   = (2 ** WSH) / DM1;
  localparam int RCPW_W = WSH + 1;

  // Interpolation datapath
  localparam int ONE      = 2 ** WEIGHT_BITS;
  localparam int WGT_W    = 2 * WEIGHT_BITS + 1;
  localparam int PROD_W   = PIX_W + WGT_W + 1;
  localparam int ACC_W    = PROD_W + 2;
  localparam int NUM_NB   = 4;
  localparam int NB_CNT_W = $clog2(NUM_NB + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef logic [HIDX_W-1:0]  hidx_t;
  typedef logic [BADDR_W-1:0] baddr_t;

  typedef struct packed {
    opcode_e           op;
    logic [BANK_W-1:0] bank;
    baddr_t            addr;
    logic [PIX_W-1:0]  pixel;
    logic [DC_W-1:0]   qrow;
    logic [DC_W-1:0]   qcol;
  } item_t;

  function automatic baddr_t bank_addr(input hidx_t rh, input hidx_t ch);
    bank_addr = BADDR_W'(BADDR_W'(rh) * BADDR_W'(HALF) + BADDR_W'(ch));
  endfunction

endpackage

@@ src/biu_front.sv @@
module biu_front import biu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    opcode_i,
  input  logic [SRC_W-1:0]        src_row_i,
  input  logic [SRC_W-1:0]        src_col_i,
  input  logic signed [PIX_W-1:0] src_pixel_i,
  input  logic [DC_W-1:0]         dst_row_i,
  input  logic [DC_W-1:0]         dst_col_i,
  output logic                    push_o,
  output item_t                   item_o,
  input  logic                    full_i
);

  logic   valid_q, valid_d;
  item_t  item_q;
  item_t  item_d;
  logic   accept;
  logic   keep;
  logic   in_image;
  logic [IDX_W-1:0] wrow, wcol;

  assign busy_o = valid_q && full_i;
  assign accept = start_i && !busy_o;
  assign push_o = valid_q && !full_i;
  assign item_o = item_q;

  // classify: loads outside the image are dropped here
  always_comb begin
    wrow     = IDX_W'(src_row_i);
    wcol     = IDX_W'(src_col_i);
    in_image = (32'(src_row_i) < SRC_SIZE) && (32'(src_col_i) < SRC_SIZE);
    keep     = (opcode_i == OP_QUERY) || in_image;

    item_d.op    = opcode_e'(opcode_i);
    item_d.bank  = {wrow[0], wcol[0]};
    item_d.addr  = bank_addr(HIDX_W'(wrow >> 1), HIDX_W'(wcol >> 1));
    item_d.pixel = src_pixel_i;
    item_d.qrow  = (32'(dst_row_i) > DM1) ? DC_W'(DM1) : dst_row_i;
    item_d.qcol  = (32'(dst_col_i) > DM1) ? DC_W'(DM1) : dst_col_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (push_o) valid_d = 1'b0;
    if (accept) valid_d = keep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

@@ src/biu_queue.sv @@
module biu_queue import biu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QP_W:0]     count_q, count_d;

  assign full_o  = (count_q == (QP_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue overflow");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue underflow");

endmodule

@@ src/biu_back.sv @@
module biu_back import biu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  item_t                   item_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic signed [PIX_W-1:0] out_pixel_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_QUOT = 8'b0000_0010,
    S_REM  = 8'b0000_0100,
    S_WEST = 8'b0000_1000,
    S_WCOR = 8'b0001_0000,
    S_WGT  = 8'b0010_0000,
    S_MAC  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } back_state_e;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2 ** (PIX_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-(2 ** (PIX_W - 1)));
  localparam logic signed [ACC_W-1:0] RND     = ACC_W'(2 ** (2 * WEIGHT_BITS - 1));

  back_state_e state_q, state_d;

  // per axis lanes: 0 = row, 1 = column
  logic [NUM_W-1:0]       num_q [2];
  logic [IDX_W-1:0]       qe_q  [2];
  logic [IDX_W-1:0]       idx_q [2];
  logic [REM_W-1:0]       rem_q [2];
  logic [WEIGHT_BITS-1:0] we_q  [2];
  logic [WEIGHT_BITS-1:0] w_q   [2];

  logic signed [PIX_W-1:0]  pix_q [NUM_NB];
  logic [WGT_W-1:0]         wgt_q [NUM_NB];
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [NB_CNT_W-1:0]      mac_cnt_q;
  logic                     done_q;
  logic signed [PIX_W-1:0]  out_pixel_q;

  logic [NUM_W+RCP_W-1:0]   qprod [2];
  logic [NUM_W-1:0]         rdiff [2];
  logic [WN_W-1:0]          wn    [2];
  logic [WN_W+RCPW_W-1:0]   wprod [2];
  logic [WN_W-1:0]          wdiff [2];
  logic [WEIGHT_BITS:0]     wfull [2];
  logic [WEIGHT_BITS:0]     wcomp [2];
  logic [IDX_W-1:0]         y1, x1;
  logic [IDX_W-1:0]         rrow [NUM_BANKS];
  logic [IDX_W-1:0]         rcol [NUM_BANKS];
  baddr_t                   rd_addr [NUM_BANKS];
  logic [PIX_W-1:0]         bank_rd [NUM_BANKS];
  logic                     rd_en;
  logic                     wr_en;
  logic signed [ACC_W-1:0]  acc_rnd, acc_sh;
  logic signed [WGT_W:0]    wgt_ext;

  assign pop_o       = (state_q == S_IDLE) && valid_i;
  assign wr_en       = pop_o && (item_i.op == OP_LOAD);
  assign rd_en       = (state_q == S_WEST);
  assign done_o      = done_q;
  assign out_pixel_o = out_pixel_q;

  // axis maths: quotient estimate, correction, weight estimate, correction
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      qprod[a] = (NUM_W + RCP_W)'(num_q[a]) * (NUM_W + RCP_W)'(RCP);
      rdiff[a] = num_q[a] - NUM_W'(NUM_W'(qe_q[a]) * NUM_W'(DM1));
      wn[a]    = {rem_q[a], {WEIGHT_BITS{1'b0}}};
      wprod[a] = (WN_W + RCPW_W)'(wn[a]) * (WN_W + RCPW_W)'(RCPW);
      wdiff[a] = wn[a] - WN_W'(WN_W'(we_q[a]) * WN_W'(DM1));
      wfull[a] = (WEIGHT_BITS + 1)'(w_q[a]);
      wcomp[a] = (WEIGHT_BITS + 1)'(ONE) - wfull[a];
    end
  end

  // neighbour rows / columns clamp at the last line
  always_comb begin
    y1 = (idx_q[0] < IDX_W'(SRC_SIZE - 1)) ? idx_q[0] + 1'b1 : idx_q[0];
    x1 = (idx_q[1] < IDX_W'(SRC_SIZE - 1)) ? idx_q[1] + 1'b1 : idx_q[1];
    for (int b = 0; b < NUM_BANKS; b++) begin
      rrow[b]    = (idx_q[0][0] == 1'(b >> 1)) ? idx_q[0] : y1;
      rcol[b]    = (idx_q[1][0] == 1'(b & 1))  ? idx_q[1] : x1;
      rd_addr[b] = bank_addr(HIDX_W'(rrow[b] >> 1), HIDX_W'(rcol[b] >> 1));
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [PIX_W-1:0] bank_mem [BANK_DEPTH];
    logic [PIX_W-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (wr_en && (item_i.bank == BANK_W'(b))) begin
        bank_mem[item_i.addr] <= item_i.pixel;
      end
      if (rd_en) begin
        rd_q <= bank_mem[rd_addr[b]];
      end
    end
    assign bank_rd[b] = rd_q;
  end

  always_comb begin
    acc_rnd = acc_q + RND;
    acc_sh  = acc_rnd >>> (2 * WEIGHT_BITS);
    wgt_ext = {1'b0, wgt_q[mac_cnt_q[1:0]]};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (pop_o && (item_i.op == OP_QUERY)) state_d = S_QUOT;
      S_QUOT:  state_d = S_REM;
      S_REM:   state_d = S_WEST;
      S_WEST:  state_d = S_WCOR;
      S_WCOR:  state_d = S_WGT;
      S_WGT:   state_d = S_MAC;
      S_MAC:   if (mac_cnt_q == NB_CNT_W'(NUM_NB)) state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mac_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_OUT);
      if (state_q == S_MAC) begin
        mac_cnt_q <= mac_cnt_q + 1'b1;
      end else begin
        mac_cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      num_q[0] <= NUM_W'(NUM_W'(item_i.qrow) * NUM_W'(SRC_SIZE - 1));
      num_q[1] <= NUM_W'(NUM_W'(item_i.qcol) * NUM_W'(SRC_SIZE - 1));
    end
    for (int a = 0; a < 2; a++) begin
      if (state_q == S_QUOT) begin
        qe_q[a] <= IDX_W'(qprod[a] >> QSH);
      end
      if (state_q == S_REM) begin
        if (rdiff[a] >= NUM_W'(DM1)) begin
          idx_q[a] <= qe_q[a] + 1'b1;
          rem_q[a] <= REM_W'(rdiff[a] - NUM_W'(DM1));
        end else begin
          idx_q[a] <= qe_q[a];
          rem_q[a] <= REM_W'(rdiff[a]);
        end
      end
      if (state_q == S_WEST) begin
        we_q[a] <= WEIGHT_BITS'(wprod[a] >> WSH);
      end
      if (state_q == S_WCOR) begin
        w_q[a] <= (wdiff[a] >= WN_W'(DM1)) ? we_q[a] + 1'b1 : we_q[a];
      end
    end
    if (state_q == S_WCOR) begin
      pix_q[0] <= bank_rd[{idx_q[0][0], idx_q[1][0]}];
      pix_q[1] <= bank_rd[{idx_q[0][0], x1[0]}];
      pix_q[2] <= bank_rd[{y1[0], idx_q[1][0]}];
      pix_q[3] <= bank_rd[{y1[0], x1[0]}];
    end
    if (state_q == S_WGT) begin
      wgt_q[0] <= WGT_W'(WGT_W'(wcomp[1]) * WGT_W'(wcomp[0]));
      wgt_q[1] <= WGT_W'(WGT_W'(wfull[1]) * WGT_W'(wcomp[0]));
      wgt_q[2] <= WGT_W'(WGT_W'(wcomp[1]) * WGT_W'(wfull[0]));
      wgt_q[3] <= WGT_W'(WGT_W'(wfull[1]) * WGT_W'(wfull[0]));
      acc_q    <= '0;
    end
    if (state_q == S_MAC) begin
      if (mac_cnt_q < NB_CNT_W'(NUM_NB)) begin
        prod_q <= PROD_W'(pix_q[mac_cnt_q[1:0]]) * PROD_W'(wgt_ext);
      end
      if (mac_cnt_q != '0) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
    if (state_q == S_OUT) begin
      if (acc_sh > SAT_MAX) begin
        out_pixel_q <= PIX_W'(SAT_MAX);
      end else if (acc_sh < SAT_MIN) begin
        out_pixel_q <= PIX_W'(SAT_MIN);
      end else begin
        out_pixel_q <= PIX_W'(acc_sh);
      end
    end
  end

  a_done_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_OUT)) else $error("result strobe without rounding step");

  a_mac_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (mac_cnt_q <= NB_CNT_W'(NUM_NB)))
    else $error("mac counter overran");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> ((state_q == S_IDLE) && !done_q || (state_q == S_IDLE)))
    else $error("pop outside idle");

  a_query_starts_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (item_i.op == OP_QUERY)) |=> (state_q == S_QUOT))
    else $error("query did not start the axis mapping");

endmodule

@@ src/bilinear_image_upscaler.sv @@
// Bilinear upscaler, corners aligned: holds a SRC_SIZE x SRC_SIZE source image
// of signed Q8.8 pixels and returns pixels of the DST_SIZE x DST_SIZE image.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. opcode_i = load writes src_pixel_i at (src_row_i, src_col_i);
// loads outside the image are dropped. opcode_i = query asks for the pixel
// at (dst_row_i, dst_col_i), coordinates above the last line are clamped.
// Result channel: done_o is high for exactly one cycle with out_pixel_o; the
// receiver cannot hold it off, so nothing on the result side ever stalls.
// A transaction is registered in the front end, then written into the queue;
// the back end pops it when idle and writes a load into its bank on the pop.
// The back end works on one transaction at a time; a query's stay there is
// set by the shared multiply-accumulate loop over the four neighbours and
// the two constant-divide steps per axis.
// The front end and a two-deep queue absorb up to three transactions while
// the back end is busy; busy rises only when all of that is full.
// Reset clears the control state only; the image banks come up undefined and
// each pixel must be loaded before a query reads it. No clearing pass runs.
module bilinear_image_upscaler import biu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    opcode_i,
  input  logic [SRC_W-1:0]        src_row_i,
  input  logic [SRC_W-1:0]        src_col_i,
  input  logic signed [PIX_W-1:0] src_pixel_i,
  input  logic [DC_W-1:0]         dst_row_i,
  input  logic [DC_W-1:0]         dst_col_i,
  output logic                    done_o,
  output logic signed [PIX_W-1:0] out_pixel_o
);

  // front -> queue
  logic  push;
  item_t push_item;
  logic  q_full;

  // queue -> back
  logic  q_valid;
  item_t q_item;
  logic  pop;

  // Front: registers the transaction, drops out-of-image loads, works out
  // the bank and in-bank address of loads and clamps query coordinates.
  biu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .opcode_i    (opcode_i),
    .src_row_i   (src_row_i),
    .src_col_i   (src_col_i),
    .src_pixel_i (src_pixel_i),
    .dst_row_i   (dst_row_i),
    .dst_col_i   (dst_col_i),
    .push_o      (push),
    .item_o      (push_item),
    .full_i      (q_full)
  );

  // Short queue so the front keeps taking transactions during a query.
  biu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // Back: four parity banks (one read each, all issued together, gives all four
  // neighbours), constant divides by reciprocal, one shared MAC, round, saturate.
  biu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .done_o      (done_o),
    .out_pixel_o (out_pixel_o)
  );

endmodule

@@ sim/tb_bilinear_image_upscaler.sv @@
// Testbench for the bilinear upscaler: loads source pixels, requests
// interpolated output pixels and checks every result against a local
// predictor that tracks the source image in step with accepted transactions.
module tb_bilinear_image_upscaler;
  import biu_pkg::*;

  // Run limit in clock periods: a wide margin over the directed tests and the
  // 730 random transactions, sender gaps included.
  localparam int CLK_PERIOD  = 20;
  localparam int LIMIT_CYCLS = 400000;
  // Slack on the tail after the last owed result has come back.
  localparam int TAIL_CYCLS  = 40;
  localparam int MAX_REPORTS = 10;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    opcode_i;
  logic [SRC_W-1:0]        src_row_i;
  logic [SRC_W-1:0]        src_col_i;
  logic signed [PIX_W-1:0] src_pixel_i;
  logic [DC_W-1:0]         dst_row_i;
  logic [DC_W-1:0]         dst_col_i;
  logic                    done_o;
  logic signed [PIX_W-1:0] out_pixel_o;

  bilinear_image_upscaler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .src_row_i   (src_row_i),
    .src_col_i   (src_col_i),
    .src_pixel_i (src_pixel_i),
    .dst_row_i   (dst_row_i),
    .dst_col_i   (dst_col_i),
    .done_o      (done_o),
    .out_pixel_o (out_pixel_o)
  );

  // Local copy of the source image, plus a flag per pixel so that a query
  // never touches a pixel that has not been loaded since reset.
  logic signed [PIX_W-1:0] src_image_model [SRC_SIZE][SRC_SIZE];
  bit                      pixel_loaded    [SRC_SIZE][SRC_SIZE];

  // Interpolated pixels still owed by the block, oldest first.
  logic signed [PIX_W-1:0] pending_pixels [$];

  int unsigned fail_cnt;
  int unsigned items_sent;
  int unsigned idle_pct;   // chance in a hundred that the sender idles a cycle

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLS);
    $display("bilinear_image_upscaler verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // One axis: output coordinate -> upper-left source index and Q0.8 weight.
  // Coordinates past the last output line are clamped to it first.
  function automatic void map_axis(input int coord, output int idx, output int wgt);
    int c;
    int num;
    int rem;
    c   = (coord > DM1) ? DM1 : coord;
    num = c * (SRC_SIZE - 1);
    idx = num / DM1;
    rem = num % DM1;
    if (idx > SRC_SIZE - 1) idx = SRC_SIZE - 1;
    wgt = (rem << WEIGHT_BITS) / DM1;
  endfunction

  // Second neighbour on an axis; sits on the first one at the last line.
  function automatic int next_idx(input int idx);
    next_idx = (idx + 1 < SRC_SIZE) ? idx + 1 : idx;
  endfunction

  // Exact sum of the four weighted neighbours, round half up, saturate.
  function automatic logic signed [PIX_W-1:0] interp_pixel(input int row, input int col);
    int     y0, x0, y1, x1, wy, wx;
    longint acc;
    map_axis(row, y0, wy);
    map_axis(col, x0, wx);
    y1  = next_idx(y0);
    x1  = next_idx(x0);
    acc = longint'(src_image_model[y0][x0]) * ((ONE - wx) * (ONE - wy))
        + longint'(src_image_model[y0][x1]) * (wx * (ONE - wy))
        + longint'(src_image_model[y1][x0]) * ((ONE - wx) * wy)
        + longint'(src_image_model[y1][x1]) * (wx * wy);
    acc = acc + (longint'(1) << (2 * WEIGHT_BITS - 1));
    acc = acc >>> (2 * WEIGHT_BITS);   // floor, acc is signed
    if (acc > 32767)  acc = 32767;
    if (acc < -32768) acc = -32768;
    interp_pixel = PIX_W'(acc);
  endfunction

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Drives one transaction and holds it until start && !busy at an edge.
  // busy is read straight after the edge, i.e. its value before the edge.
  task automatic issue_item(input opcode_e op, input int sr, input int sc,
                            input logic [PIX_W-1:0] px, input int dr, input int dc);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    opcode_i    <= op;
    src_row_i   <= SRC_W'(sr);
    src_col_i   <= SRC_W'(sc);
    src_pixel_i <= px;
    dst_row_i   <= DC_W'(dr);
    dst_col_i   <= DC_W'(dc);
    do @(posedge clk_i); while (busy);
    // Accepted: update the image copy, or predict the query's result
    if (op == OP_QUERY) begin
      pending_pixels.push_back(interp_pixel(dr & 8'hFF, dc & 8'hFF));
    end else if (sr < SRC_SIZE && sc < SRC_SIZE) begin
      src_image_model[sr][sc] = px;
      pixel_loaded[sr][sc]    = 1'b1;
    end
    items_sent++;
  endtask

  // The unused half of the fields carries noise on every transaction.
  task automatic load_pixel(input int row, input int col, input logic [PIX_W-1:0] px);
    issue_item(OP_LOAD, row, col, px, $urandom_range(255), $urandom_range(255));
  endtask

  task automatic query_pixel(input int row, input int col);
    issue_item(OP_QUERY, $urandom_range(31), $urandom_range(31), PIX_W'($urandom),
               row, col);
  endtask

  // Sender stops and waits for every owed result.
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0:       rand_pixel = 16'h7FFF;
      1:       rand_pixel = 16'h8000;
      2:       rand_pixel = 16'h0000;
      default: rand_pixel = PIX_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: done_o marks a result for exactly one cycle
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    logic signed [PIX_W-1:0] want;
    if (rst_ni && done_o) begin
      if (pending_pixels.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("unexpected result: out_pixel %0d with nothing pending", out_pixel_o);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_o !== want) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("out_pixel mismatch: expected %0d (%h), got %0d (%h)",
                     want, want, out_pixel_o, out_pixel_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Top-left corner at full scale: exact corner, mid weights, largest weight
  // before the index steps.
  task automatic test_corner_extremes();
    load_pixel(0, 0, 16'h7FFF);
    load_pixel(0, 1, 16'h7FFF);
    load_pixel(1, 0, 16'h7FFF);
    load_pixel(1, 1, 16'h7FFF);
    query_pixel(0, 0);
    query_pixel(4, 4);
    query_pixel(8, 8);
    wait_for_results();
  endtask

  // Bottom-right corner, three pixels at negative full scale: neighbour clamp on the last
  // line, and output coordinates past the image saturated onto it.
  task automatic test_last_line_clamp();
    load_pixel(26, 26, 16'h8000);
    load_pixel(26, 27, 16'h7FFF);
    load_pixel(27, 26, 16'h8000);
    load_pixel(27, 27, 16'h8000);
    query_pixel(DST_SIZE - 1, DST_SIZE - 1);
    query_pixel(255, DST_SIZE);
    query_pixel(DST_SIZE - 2, DST_SIZE - 2);
    wait_for_results();
  endtask

  // Loads outside the image must not land anywhere.
  task automatic test_ignored_loads();
    load_pixel(31, 0, 16'h5555);
    load_pixel(0, SRC_SIZE, 16'h5555);
    load_pixel(SRC_SIZE, 31, 16'hAAAA);
    query_pixel(0, 0);
    query_pixel(DST_SIZE - 1, DST_SIZE - 1);
    wait_for_results();
  endtask

  // Column 4 gives weight 123/256; with 0 and +/-128 either side the exact
  // value lands on a half, which must round towards plus infinity.
  task automatic test_rounding_ties();
    load_pixel(0, 0, 16'h0000);
    load_pixel(0, 1, 16'h0080);
    query_pixel(0, 4);
    load_pixel(0, 1, 16'hFF80);
    query_pixel(0, 4);
    wait_for_results();
  endtask

  // Mostly queries over random coordinates; any neighbour not yet loaded is
  // loaded first, so the image fills up as the run goes on. The rest is
  // loads at random in-image pixels and loads that fall outside the image.
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle);
    int unsigned goal;
    int          dr, dc, y0, x0, wy, wx;
    idle_pct = idle;
    goal     = items_sent + n_items;
    while (items_sent < goal) begin
      case ($urandom_range(99)) inside
        [0:7]: begin
          if ($urandom_range(1))
            load_pixel($urandom_range(31, SRC_SIZE), $urandom_range(31), rand_pixel());
          else
            load_pixel($urandom_range(31), $urandom_range(31, SRC_SIZE), rand_pixel());
        end
        [8:29]: load_pixel($urandom_range(SRC_SIZE - 1), $urandom_range(SRC_SIZE - 1),
                           rand_pixel());
        default: begin
          dr = ($urandom_range(7) == 0) ? $urandom_range(255, DST_SIZE)
                                        : $urandom_range(DST_SIZE - 1);
          dc = ($urandom_range(7) == 0) ? $urandom_range(255, DST_SIZE)
                                        : $urandom_range(DST_SIZE - 1);
          map_axis(dr, y0, wy);
          map_axis(dc, x0, wx);
          if (!pixel_loaded[y0][x0])                   load_pixel(y0, x0, rand_pixel());
          if (!pixel_loaded[y0][next_idx(x0)])         load_pixel(y0, next_idx(x0), rand_pixel());
          if (!pixel_loaded[next_idx(y0)][x0])         load_pixel(next_idx(y0), x0, rand_pixel());
          if (!pixel_loaded[next_idx(y0)][next_idx(x0)])
            load_pixel(next_idx(y0), next_idx(x0), rand_pixel());
          query_pixel(dr, dc);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    fail_cnt    = 0;
    items_sent  = 0;
    idle_pct    = 24;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    opcode_i    <= OP_LOAD;
    src_row_i   <= '0;
    src_col_i   <= '0;
    src_pixel_i <= '0;
    dst_row_i   <= '0;
    dst_col_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_extremes();
    test_last_line_clamp();
    test_ignored_loads();
    test_rounding_ties();

    test_random_traffic(250, 24);
    test_random_traffic(200, 0);   // back-to-back, no sender gaps
    wait_for_results();            // sender holds off until all is in
    test_random_traffic(280, 24);

    wait_for_results();
    repeat (TAIL_CYCLS) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("bilinear_image_upscaler verification clean");
    end else begin
      $display("bilinear_image_upscaler verification failed");
    end
    $finish;
  end

endmodule
